// ===== hw/rtl/lsat_pkg.sv =====
// Package for the linear-search associative table: sizes, result codes,
// controller state type and the command/status structs between control and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsat_pkg;

  // Table capacity and stored field widths
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Port field widths (fixed)
  localparam int KEY_FIELD_W   = 32;
  localparam int VALUE_FIELD_W = 32;
  localparam int STATUS_W      = 2;

  // Stored widths: only the low bits of each field are kept
  localparam int KEY_W   = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int VALUE_W = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;

  // Slot index and entry count widths
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Request codes
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ADDED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_LOOKUP = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch the request, reset the scan
    logic scan_step;  // advance the key scan by one slot
    logic finish;     // commit the add and load the result register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;  // scan reached the end or found a match, pipeline empty
    logic out_busy;   // result register holds a transfer that is stalled
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsat_ctl.sv =====
// Controller for the linear-search associative table: sequences one request at a time.
// Depends on lsat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsat_ctl
  import lsat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     req_type,
  output logic          in_stall,
  output ctl_cmd_t      cmd,
  input  wire ctl_sts_t sts
);

  ctl_state_t state;
  ctl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (req_type == REQ_LOOKUP) ? S_SCAN : S_ADD;
        end
      end
      S_ADD: begin
        if (!sts.out_busy) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_done && !sts.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall      = 1'b1;
    cmd.capture   = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.finish    = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_ADD: begin
        cmd.finish = !sts.out_busy;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.finish    = sts.scan_done && !sts.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lsat_dp.sv =====
// Datapath for the linear-search associative table: key/value stores, entry count,
// pipelined key scan and the result register.
// Depends on lsat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsat_dp
  import lsat_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctl_cmd_t                 cmd,
  output ctl_sts_t                      sts,
  input  wire logic                     req_type,
  input  wire logic [KEY_FIELD_W-1:0]   key,
  input  wire logic [VALUE_FIELD_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [STATUS_W-1:0]           status,
  output logic                          found,
  output logic [VALUE_FIELD_W-1:0]      found_value
);

  // Stores
  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic [VALUE_W-1:0] val_mem [ENTRIES];

  // Request registers
  logic               req_lookup;
  logic [KEY_W-1:0]   req_key;
  logic [VALUE_W-1:0] req_val;

  // Scan state
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic               rd_vld;
  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_val;
  logic               hit;
  logic [VALUE_W-1:0] hit_val;

  // Result register
  logic [STATUS_W-1:0]      res_status;
  logic                     res_found;
  logic [VALUE_FIELD_W-1:0] res_value;

  logic full;
  logic rd_en;
  logic match;
  logic do_write;

  assign full     = (count == CNT_W'(ENTRIES));
  assign rd_en    = (idx < count) && !hit;
  assign match    = rd_vld && (rd_key == req_key) && !hit;
  assign do_write = cmd.finish && !req_lookup && !full;

  assign sts.scan_done = !rd_vld && (hit || (idx >= count));
  assign sts.out_busy  = out_valid && out_stall;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // finish is only issued once the previous result has left
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.capture) begin
        idx    <= '0;
        rd_vld <= 1'b0;
        hit    <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld <= rd_en;
        if (rd_en) begin
          idx <= idx + CNT_W'(1);
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      if (do_write) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Request capture, store access and scan data
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_lookup <= req_type;
      req_key    <= key[KEY_W-1:0];
      req_val    <= value[VALUE_W-1:0];
    end
    if (cmd.scan_step && rd_en) begin
      rd_key <= key_mem[idx[IDX_W-1:0]];
      rd_val <= val_mem[idx[IDX_W-1:0]];
    end
    if (cmd.scan_step && match) begin
      hit_val <= rd_val;
    end
    if (do_write) begin
      key_mem[count[IDX_W-1:0]] <= req_key;
      val_mem[count[IDX_W-1:0]] <= req_val;
    end
  end

  // Result register load
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (req_lookup) begin
        res_status <= STAT_LOOKUP;
        res_found  <= hit;
        res_value  <= hit ? VALUE_FIELD_W'(hit_val) : '0;
      end else begin
        res_status <= full ? STAT_FULL : STAT_ADDED;
        res_found  <= 1'b0;
        res_value  <= '0;
      end
    end
  end

  assign status      = res_status;
  assign found       = res_found;
  assign found_value = res_value;

endmodule

`default_nettype wire

// ===== hw/rtl/linear_search_assoc_table.sv =====
// Top level of the linear-search associative table: controller plus datapath.
// Depends on lsat_pkg, lsat_ctl, lsat_dp.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   req_type, key, value
//   out      out_valid / out_stall status, found, found_value
//
// One request at a time. An add passes the request registers and the add state on its way
// to the result register; a lookup scans the stored entries one slot per cycle through the
// key store read port, stopping early on a match.
// Reset (rst, synchronous) empties the table; the stores themselves are not cleared.
// The result sits in an output register; a stalled result holds the block at
// completion of the next request, and a new request is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module linear_search_assoc_table
  import lsat_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     req_type,
  input  wire logic [KEY_FIELD_W-1:0]   key,
  input  wire logic [VALUE_FIELD_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [STATUS_W-1:0]           status,
  output logic                          found,
  output logic [VALUE_FIELD_W-1:0]      found_value
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer
  lsat_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Stores, scan and result register
  lsat_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .found_value (found_value)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lsat_chk.sv =====
// Port-level checker for the linear-search associative table, bound to the top level.
// Depends on lsat_pkg and linear_search_assoc_table.
`timescale 1ns / 1ps
`default_nettype none

module lsat_chk
  import lsat_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [STATUS_W-1:0]      status,
  input wire logic                     found,
  input wire logic [VALUE_FIELD_W-1:0] found_value
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(found) && $stable(found_value))
    else $error("result payload changed while stalled");

  // Only one request in flight: input stalls right after a transfer
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // Add results never report a match
  a_add_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_ADDED || status == STAT_FULL) |-> !found)
    else $error("add result reports a match");

  // A miss returns a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> found_value == '0)
    else $error("nonzero value without a match");

endmodule

bind linear_search_assoc_table lsat_chk u_lsat_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .found       (found),
  .found_value (found_value)
);

`default_nettype wire

// ===== bench/linear_search_assoc_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench for linear_search_assoc_table: directed and random add/lookup transfers
// with bursty input, patterned output stall and one long hold, checked against a predictor.
// Depends on lsat_pkg and the linear_search_assoc_table RTL.

module linear_search_assoc_table_tb;
  import lsat_pkg::*;

  localparam int RANDOM_REQS  = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_START   = 1500;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

  typedef struct packed {
    logic                     req_type;
    logic [KEY_FIELD_W-1:0]   key;
    logic [VALUE_FIELD_W-1:0] value;
  } table_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic [VALUE_FIELD_W-1:0] found_value;
  } table_resp_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     req_type = REQ_ADD;
  logic [KEY_FIELD_W-1:0]   req_key = '0;
  logic [VALUE_FIELD_W-1:0] req_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic                     found;
  logic [VALUE_FIELD_W-1:0] found_value;

  // stimulus and expectations
  table_req_t               pending_reqs[$];
  logic [KEY_FIELD_W-1:0]   stored_keys[$];
  table_resp_t              expected_responses[$];
  table_req_t               offered_req;
  int                       total_reqs = 0;
  int                       accepted_count = 0;
  int                       results_checked = 0;
  int                       error_count = 0;
  int                       adds_stored = 0;
  int                       adds_refused = 0;
  int                       lookup_hits = 0;
  int                       lookup_misses = 0;

  // predictor copy of the table
  logic [KEY_W-1:0]         shadow_keys[ENTRIES];
  logic [VALUE_W-1:0]       shadow_values[ENTRIES];
  int                       shadow_count = 0;

  // sender and receiver pacing
  int                       burst_left = 8;
  int                       gap_left = 0;
  int                       hold_left = 0;
  int                       rx_cycles = 0;
  int                       idle_cycles = 0;

  linear_search_assoc_table dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .key        (req_key),
    .value      (req_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .found      (found),
    .found_value(found_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the shadow table and return the response it should give
  function automatic table_resp_t predict_table_response(table_req_t r);
    table_resp_t resp;
    resp = '0;
    if (r.req_type == REQ_ADD) begin
      if (shadow_count >= ENTRIES) begin
        resp.status = STAT_FULL;
      end else begin
        shadow_keys[shadow_count]   = r.key[KEY_W-1:0];
        shadow_values[shadow_count] = r.value[VALUE_W-1:0];
        shadow_count++;
        resp.status = STAT_ADDED;
      end
    end else begin
      resp.status = STAT_LOOKUP;
      // oldest match wins
      for (int i = 0; i < shadow_count; i++) begin
        if (!resp.found && shadow_keys[i] == r.key[KEY_W-1:0]) begin
          resp.found       = 1'b1;
          resp.found_value = VALUE_FIELD_W'(shadow_values[i]);
        end
      end
    end
    return resp;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Queue a request; the first ENTRIES adds are the ones the table keeps
  task automatic queue_req(logic rt, logic [KEY_FIELD_W-1:0] k, logic [VALUE_FIELD_W-1:0] v);
    table_req_t r;
    r.req_type = rt;
    r.key      = k;
    r.value    = v;
    pending_reqs.push_back(r);
    if (rt == REQ_ADD && stored_keys.size() < ENTRIES) stored_keys.push_back(k);
  endtask

  // Input driver: takes the offered transfer, then offers the next item or a gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        table_resp_t resp;
        resp = predict_table_response(offered_req);
        expected_responses.push_back(resp);
        accepted_count++;
        if (resp.status == STAT_ADDED) adds_stored++;
        else if (resp.status == STAT_FULL) adds_refused++;
        else if (resp.found) lookup_hits++;
        else lookup_misses++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          offered_req = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          req_type  <= offered_req.req_type;
          req_key   <= offered_req.key;
          req_value <= offered_req.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output receiver: one long hold, otherwise rotating stall patterns
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == HOLD_START) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((rx_cycles / 64) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ((rx_cycles % 5) < 2);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d found %0b value %h",
                                  status, found, found_value));
      end else begin
        table_resp_t want;
        want = expected_responses.pop_front();
        results_checked++;
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (found !== want.found)
          report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
        if (found_value !== want.found_value)
          report_mismatch($sformatf("found_value %h, expected %h", found_value, want.found_value));
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, %0d of %0d requests taken",
                 IDLE_LIMIT, accepted_count, total_reqs);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [KEY_FIELD_W-1:0] k;
    int                     pick;

    // directed: empty table, extreme keys and values, duplicates, full table
    queue_req(REQ_LOOKUP, '0, $urandom);
    queue_req(REQ_ADD, '0, '0);
    queue_req(REQ_ADD, '1, '1);
    queue_req(REQ_ADD, '0, 32'h5a5a_a5a5);
    queue_req(REQ_LOOKUP, '0, '1);
    queue_req(REQ_LOOKUP, '1, '0);
    queue_req(REQ_LOOKUP, 32'h1, $urandom);
    for (int i = 0; i < ENTRIES - 3; i++) begin
      // one more duplicate of the all-ones key partway in
      queue_req(REQ_ADD, (i == 4) ? '1 : $urandom, $urandom);
    end
    queue_req(REQ_ADD, $urandom, $urandom);
    queue_req(REQ_LOOKUP, stored_keys[ENTRIES-1], $urandom);
    queue_req(REQ_ADD, '0, '1);
    queue_req(REQ_LOOKUP, stored_keys[10], $urandom);

    // random: mostly lookups of held keys, some near misses, misses and refused adds
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      k = stored_keys[$urandom_range(0, ENTRIES - 1)];
      if (pick < 20) queue_req(REQ_ADD, $urandom, $urandom);
      else if (pick < 30) queue_req(REQ_LOOKUP, k ^ (32'h1 << $urandom_range(0, 31)), $urandom);
      else if (pick < 50) queue_req(REQ_LOOKUP, $urandom, $urandom);
      else queue_req(REQ_LOOKUP, k, $urandom);
    end
    total_reqs = pending_reqs.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_reqs || expected_responses.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d adds stored, %0d adds refused on a full table",
             total_reqs, adds_stored, adds_refused);
    $display("%0d lookups hit, %0d missed; %0d results checked, %0d mismatches",
             lookup_hits, lookup_misses, results_checked, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
